// ===== hw/rtl/sdf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_pkg: shared definitions for the signed decimal field formatter
// Widths of the fixed fields, character codes, register indexes, the
// configuration bundle and the state encodings of the front and back parts.
// ----------------------------------------------------------------------------
package sdf_pkg;

  // Default sizing, handed down from the top level
  localparam int MAX_DIGITS_DEF = 10;
  localparam int MAX_FIELD_DEF  = 64;
  localparam int QUEUE_DEPTH    = 2;

  // Fixed field widths
  localparam int VALUE_W       = 32;
  localparam int CHAR_W        = 8;
  localparam int DIGIT_W       = 4;
  localparam int FIELD_WIDTH_W = 7;
  localparam int PRECISION_W   = 6;
  localparam int REG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 7;

  // Divide by ten: multiply by ceil(2^35 / 10) and keep the top bits
  localparam logic [32:0] RECIP_10    = 33'h0_CCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;
  localparam int          QUOT_W      = 29;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // Register indexes on the write port
  localparam logic [REG_IDX_W-1:0] REG_FIELD_WIDTH     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DIGIT_PRECISION = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FLAG_PLUS       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FLAG_BLANK      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FLAG_ZERO       = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FLAG_LEFT       = 3'd5;

  // Configuration bundle seen by the front and back parts
  typedef struct packed {
    logic [FIELD_WIDTH_W-1:0] field_width;
    logic [PRECISION_W-1:0]   digit_precision;
    logic                     flag_plus;
    logic                     flag_blank;
    logic                     flag_zero;
    logic                     flag_left;
  } cfg_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_CONV,
    FR_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PLAN,
    BK_EMIT
  } back_state_t;

endpackage

// ===== hw/rtl/sdf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_front: value intake and digit conversion
// Takes one value, picks its sign character, then splits the magnitude into
// decimal digits, one per cycle, and hands the result to the queue.
// ----------------------------------------------------------------------------
module sdf_front
  import sdf_pkg::*;
#(
  parameter  int MAX_DIGITS = MAX_DIGITS_DEF,
  localparam int NDIG_W     = $clog2(MAX_DIGITS + 1),
  localparam int DIG_IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  cfg_t                            cfg,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [VALUE_W-1:0]       value,
  output logic                            push,
  input  logic                            full,
  output logic [CHAR_W-1:0]               sign_char,
  output logic [NDIG_W-1:0]               ndig,
  output logic [MAX_DIGITS*DIGIT_W-1:0]   digits
);

  front_state_t state, state_next;

  logic [VALUE_W-1:0] rem_value;
  logic [DIGIT_W-1:0] dig [MAX_DIGITS];

  logic               accept;
  logic [VALUE_W-1:0] raw;
  logic [VALUE_W-1:0] mag;
  logic [63:0]        prod;
  logic [VALUE_W-1:0] quot;
  logic [VALUE_W-1:0] quot_x10;
  logic [VALUE_W-1:0] rem_full;
  logic               conv_done;

  assign accept = in_valid && !in_stall;

  // Magnitude of the incoming value, exact for the most negative one
  assign raw = value;
  assign mag = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;

  // One decimal digit per cycle by reciprocal multiply
  assign prod      = 64'(rem_value) * 64'(RECIP_10);
  assign quot      = VALUE_W'(prod[RECIP_SHIFT +: QUOT_W]);
  assign quot_x10  = (quot << 3) + (quot << 1);
  assign rem_full  = rem_value - quot_x10;
  assign conv_done = (quot == '0) || (ndig == NDIG_W'(MAX_DIGITS - 1));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      FR_IDLE: if (accept) state_next = FR_CONV;
      FR_CONV: if (conv_done) state_next = FR_PUSH;
      FR_PUSH: if (!full) state_next = FR_IDLE;
      default: state_next = FR_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_stall = (state != FR_IDLE);
    push     = (state == FR_PUSH) && !full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      rem_value <= mag;
      ndig      <= '0;
      if (raw[VALUE_W-1]) begin
        sign_char <= CH_MINUS;
      end else if (cfg.flag_plus) begin
        sign_char <= CH_PLUS;
      end else if (cfg.flag_blank) begin
        sign_char <= CH_SPACE;
      end else begin
        sign_char <= CH_NONE;
      end
    end else if (state == FR_CONV) begin
      dig[ndig[DIG_IDX_W-1:0]] <= rem_full[DIGIT_W-1:0];
      ndig                     <= ndig + NDIG_W'(1);
      rem_value                <= quot;
    end
  end

  // Digit store flattened for the queue, least significant first
  for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_pack
    assign digits[g*DIGIT_W +: DIGIT_W] = dig[g];
  end

endmodule

// ===== hw/rtl/sdf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_queue: short descriptor queue
// Holds converted values between the front and back parts so that each side
// stalls on its own.
// ----------------------------------------------------------------------------
module sdf_queue
  import sdf_pkg::*;
#(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/sdf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_back: field layout and character emission
// Takes one converted value from the queue, sizes the sign, fill, leading
// zeros and digits, then sends one character per cycle unless stalled.
// ----------------------------------------------------------------------------
module sdf_back
  import sdf_pkg::*;
#(
  parameter  int MAX_DIGITS = MAX_DIGITS_DEF,
  parameter  int MAX_FIELD  = MAX_FIELD_DEF,
  localparam int NDIG_W     = $clog2(MAX_DIGITS + 1),
  localparam int DIG_IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1,
  localparam int POS_W      = $clog2(MAX_FIELD + MAX_DIGITS + 2)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  logic                          empty,
  output logic                          pop,
  input  logic [CHAR_W-1:0]             q_sign_char,
  input  logic [NDIG_W-1:0]             q_ndig,
  input  logic [MAX_DIGITS*DIGIT_W-1:0] q_digits,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [CHAR_W-1:0]             out_char,
  output logic                          last_char
);

  back_state_t state, state_next;

  // Current descriptor
  logic [CHAR_W-1:0]  sign_char;
  logic [NDIG_W-1:0]  ndig;
  logic [DIGIT_W-1:0] dig [MAX_DIGITS];

  // Layout, as end positions of each part
  logic [POS_W-1:0] lead_end;
  logic [POS_W-1:0] zeros_end;
  logic [POS_W-1:0] digits_end;
  logic [POS_W-1:0] limit;
  logic [POS_W-1:0] pos;

  logic             slen;
  logic [POS_W-1:0] w_sat;
  logic [POS_W-1:0] p_sat;
  logic [POS_W-1:0] ndig_p;
  logic [POS_W-1:0] precz;
  logic [POS_W-1:0] core;
  logic [POS_W-1:0] pad;
  logic [POS_W-1:0] lead_end_next;
  logic [POS_W-1:0] zeros_end_next;
  logic [POS_W-1:0] digits_end_next;
  logic [POS_W-1:0] total;
  logic [POS_W-1:0] limit_next;

  logic              load;
  logic              is_last;
  logic              sign_pos;
  logic [CHAR_W-1:0] fill_c;
  logic [POS_W-1:0]  dig_off;
  logic [DIGIT_W-1:0] cur_digit;
  logic [CHAR_W-1:0] char_next;

  // Layout arithmetic, registered in the planning cycle
  always_comb begin
    slen   = (sign_char != CH_NONE);
    w_sat  = (cfg.field_width > FIELD_WIDTH_W'(MAX_FIELD)) ? POS_W'(MAX_FIELD)
                                                           : POS_W'(cfg.field_width);
    p_sat  = (cfg.digit_precision > PRECISION_W'(MAX_FIELD - 1)) ? POS_W'(MAX_FIELD - 1)
                                                                 : POS_W'(cfg.digit_precision);
    ndig_p = POS_W'(ndig);
    precz  = (p_sat > ndig_p) ? (p_sat - ndig_p) : '0;
    core   = ndig_p + POS_W'(slen) + precz;
    pad    = (w_sat > core) ? (w_sat - core) : '0;
    lead_end_next   = POS_W'(slen) + (cfg.flag_left ? '0 : pad);
    zeros_end_next  = lead_end_next + precz;
    digits_end_next = zeros_end_next + ndig_p;
    total           = core + pad;
    limit_next      = (total > POS_W'(MAX_FIELD)) ? POS_W'(MAX_FIELD) : total;
  end

  // Character at the current position
  always_comb begin
    fill_c    = cfg.flag_zero ? CH_ZERO : CH_SPACE;
    sign_pos  = cfg.flag_zero ? (pos == '0) : (pos == lead_end - POS_W'(1));
    dig_off   = digits_end - POS_W'(1) - pos;
    cur_digit = dig[dig_off[DIG_IDX_W-1:0]];
    if (pos < lead_end) begin
      char_next = (slen && sign_pos) ? sign_char : fill_c;
    end else if (pos < zeros_end) begin
      char_next = CH_ZERO;
    end else if (pos < digits_end) begin
      char_next = CH_ZERO + CHAR_W'(cur_digit);
    end else begin
      char_next = fill_c;
    end
    is_last = (pos == limit - POS_W'(1));
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (!empty) state_next = BK_PLAN;
      BK_PLAN: state_next = BK_EMIT;
      BK_EMIT: if (load && is_last) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    pop  = (state == BK_IDLE) && !empty;
    load = (state == BK_EMIT) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Descriptor, layout and output registers
  always_ff @(posedge clk) begin
    if (pop) begin
      sign_char <= q_sign_char;
      ndig      <= q_ndig;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        dig[i] <= q_digits[i*DIGIT_W +: DIGIT_W];
      end
    end
    if (state == BK_PLAN) begin
      lead_end   <= lead_end_next;
      zeros_end  <= zeros_end_next;
      digits_end <= digits_end_next;
      limit      <= limit_next;
      pos        <= '0;
    end else if (load) begin
      pos <= pos + POS_W'(1);
    end
    if (load) begin
      out_char  <= char_next;
      last_char <= is_last;
    end
  end

endmodule

// ===== hw/rtl/signed_decimal_field_formatter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_decimal_field_formatter: printf-style %d text generator
// Turns each signed 32-bit value into its formatted decimal text, sent as a
// run of ASCII characters with the final one marked.
// ----------------------------------------------------------------------------
// Each accepted value comes out as a run of 1 to MAX_FIELD characters (up to
// 64), one character per cycle on the output channel unless it is stalled,
// with last_char set on the final one. The output side sets the pace: each
// value is taken from the queue, its field is laid out, then its characters
// are transferred. The digit conversion ahead of it runs while the previous
// run is still being sent; a two-entry queue sits between the two. The input
// is stalled while a value is being converted, and for longer once both
// queue entries are waiting. There is no clearing pass after reset.
// Configuration (width, precision, flags) may only be written while no
// value is in flight.
module signed_decimal_field_formatter
  import sdf_pkg::*;
#(
  parameter  int MAX_DIGITS = MAX_DIGITS_DEF,
  parameter  int MAX_FIELD  = MAX_FIELD_DEF,
  localparam int NDIG_W     = $clog2(MAX_DIGITS + 1),
  localparam int DESC_W     = CHAR_W + NDIG_W + MAX_DIGITS * DIGIT_W
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration writes
  input  logic                      wr_en,
  input  logic [REG_IDX_W-1:0]      wr_index,
  input  logic [CFG_DATA_W-1:0]     wr_data,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [VALUE_W-1:0] value,
  // output channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [CHAR_W-1:0]         out_char,
  output logic                      last_char
);

  cfg_t cfg;

  logic                          push;
  logic                          full;
  logic                          pop;
  logic                          empty;
  logic [CHAR_W-1:0]             fr_sign_char;
  logic [NDIG_W-1:0]             fr_ndig;
  logic [MAX_DIGITS*DIGIT_W-1:0] fr_digits;
  logic [DESC_W-1:0]             q_wdata;
  logic [DESC_W-1:0]             q_rdata;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_FIELD_WIDTH:     cfg.field_width     <= wr_data[FIELD_WIDTH_W-1:0];
        REG_DIGIT_PRECISION: cfg.digit_precision <= wr_data[PRECISION_W-1:0];
        REG_FLAG_PLUS:       cfg.flag_plus       <= wr_data[0];
        REG_FLAG_BLANK:      cfg.flag_blank      <= wr_data[0];
        REG_FLAG_ZERO:       cfg.flag_zero       <= wr_data[0];
        REG_FLAG_LEFT:       cfg.flag_left       <= wr_data[0];
        default: ;
      endcase
    end
  end

  sdf_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .push      (push),
    .full      (full),
    .sign_char (fr_sign_char),
    .ndig      (fr_ndig),
    .digits    (fr_digits)
  );

  assign q_wdata = {fr_sign_char, fr_ndig, fr_digits};

  sdf_queue #(
    .WIDTH(DESC_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (q_wdata),
    .full  (full),
    .pop   (pop),
    .rdata (q_rdata),
    .empty (empty)
  );

  sdf_back #(
    .MAX_DIGITS(MAX_DIGITS),
    .MAX_FIELD (MAX_FIELD)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .empty       (empty),
    .pop         (pop),
    .q_sign_char (q_rdata[DESC_W-1 -: CHAR_W]),
    .q_ndig      (q_rdata[MAX_DIGITS*DIGIT_W +: NDIG_W]),
    .q_digits    (q_rdata[MAX_DIGITS*DIGIT_W-1:0]),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .last_char   (last_char)
  );

endmodule

// ===== hw/rtl/sdf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_checker: port-level checks for the formatter
// Watches the channels of the top level and flags timing or content slips.
// ----------------------------------------------------------------------------
module sdf_checker
  import sdf_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [CHAR_W-1:0]         out_char,
  input logic                      last_char
);

  // A held character does not change or vanish
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(last_char))
    else $error("output transfer changed while stalled");

  // Conversion keeps the intake busy for at least the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again straight after a transfer");

  // Nothing comes out in the first cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !out_valid)
    else $error("output valid straight after reset");

  // Only sign, fill and digit characters appear
  a_char_set: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_char == CH_PLUS) || (out_char == CH_MINUS) ||
                  (out_char == CH_SPACE) ||
                  ((out_char >= CH_ZERO) && (out_char <= CH_NINE)))
    else $error("character outside the decimal text set");

endmodule

bind signed_decimal_field_formatter sdf_checker u_checker (.*);
